// File: hw/rtl/hpq_pkg.sv
// ============================================================================
// hpq_pkg
// Shared types and constants for the binary heap priority queue: operation
// and status codes, configuration register indexes, and controller states.
// ============================================================================
package hpq_pkg;

    localparam int DEPTH_DEF    = 64;
    localparam int KEY_BITS_DEF = 32;

    // Entry count and configuration port widths
    localparam int CNT_W     = 7;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

    // Operation codes carried in the func field
    typedef enum logic [1:0] {
        FN_INSERT  = 2'd0,
        FN_POP     = 2'd1,
        FN_REPLACE = 2'd2
    } func_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORDER_MODE = 1'b0,
        REG_CAPACITY   = 1'b1
    } cfg_reg_t;

    // Configuration handed to the controller
    typedef struct packed {
        logic             order_mode;
        logic [CNT_W-1:0] capacity_limit;
    } cfg_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LAST,
        S_DN_L,
        S_DN_R,
        S_DN_CMP,
        S_UP_CHK,
        S_UP_CMP,
        S_OUT
    } state_t;

endpackage

// File: hw/rtl/hpq_cmd_if.sv
// ============================================================================
// hpq_cmd_if
// Command channel: one word carries an operation code and a key.
// ============================================================================
interface hpq_cmd_if #(
    parameter int KEY_BITS = hpq_pkg::KEY_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic [1:0]          func;
    logic [KEY_BITS-1:0] key;

    modport source (output valid, output func, output key, input ready);
    modport sink   (input valid, input func, input key, output ready);
endinterface

// File: hw/rtl/hpq_rsp_if.sv
// ============================================================================
// hpq_rsp_if
// Response channel: one word per command, describing the heap afterwards.
// ============================================================================
interface hpq_rsp_if #(
    parameter int KEY_BITS = hpq_pkg::KEY_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic [KEY_BITS-1:0]     top_key;
    logic                    top_valid;
    logic [hpq_pkg::CNT_W-1:0] entry_total;
    logic [KEY_BITS-1:0]     popped_key;
    logic [1:0]              status;

    modport source (output valid, output top_key, output top_valid, output entry_total,
                    output popped_key, output status, input ready);
    modport sink   (input valid, input top_key, input top_valid, input entry_total,
                    input popped_key, input status, output ready);
endinterface

// File: hw/rtl/binary_heap_priority_queue.sv
// One word is in work at a time; the next is accepted once its result is loaded into
// the response register, and a stalled response word holds back that load.
// Reset clears the entry count, sets order_mode 0 and capacity_limit 64; the
// key RAM is not cleared, since entries are always written before being read.
// ============================================================================
// binary_heap_priority_queue
// Top level: configuration registers, key RAM and heap sequencer.
// ============================================================================
module binary_heap_priority_queue #(
    parameter int DEPTH    = hpq_pkg::DEPTH_DEF,
    parameter int KEY_BITS = hpq_pkg::KEY_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    hpq_cmd_if.sink                       cmd,
    hpq_rsp_if.source                     rsp,
    input  logic                          cfg_we,
    input  logic [hpq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hpq_pkg::CFG_W-1:0]     cfg_data
);

    localparam int AW = $clog2(DEPTH);

    logic                          order_mode_reg;
    logic [hpq_pkg::CNT_W-1:0]     capacity_reg;
    hpq_pkg::cfg_t                 cfg;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [KEY_BITS-1:0] ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [KEY_BITS-1:0] ram_rdata;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_mode_reg <= 1'b0;
            capacity_reg   <= hpq_pkg::CAP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hpq_pkg::REG_ORDER_MODE: order_mode_reg <= cfg_data[0];
                hpq_pkg::REG_CAPACITY:   capacity_reg   <= cfg_data;
                default:                 ;
            endcase
        end
    end

    assign cfg.order_mode     = order_mode_reg;
    assign cfg.capacity_limit = capacity_reg;

    // Key store
    hpq_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Heap sequencer
    hpq_ctrl #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .rsp       (rsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

endmodule

// File: hw/rtl/hpq_ram.sv
// ============================================================================
// hpq_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ============================================================================
module hpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/hpq_ctrl.sv
// ============================================================================
// hpq_ctrl
// Heap sequencer: runs insert / pop / replace against the key RAM using a
// hole-based sift (the moving key stays in a register and is written once
// at its final slot), keeps the entry count and a copy of the top entry,
// and holds the response word in an output register.
// ============================================================================
module hpq_ctrl #(
    parameter int DEPTH    = hpq_pkg::DEPTH_DEF,
    parameter int KEY_BITS = hpq_pkg::KEY_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  hpq_pkg::cfg_t            cfg,
    hpq_cmd_if.sink                  cmd,
    hpq_rsp_if.source                rsp,
    output logic                     ram_we,
    output logic [$clog2(DEPTH)-1:0] ram_waddr,
    output logic [KEY_BITS-1:0]      ram_wdata,
    output logic [$clog2(DEPTH)-1:0] ram_raddr,
    input  logic [KEY_BITS-1:0]      ram_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = hpq_pkg::CNT_W;
    localparam int XW = (AW + 2 > CW) ? AW + 2 : CW;

    hpq_pkg::state_t  state_reg, state_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [XW-1:0]       end_reg, end_next;
    logic [KEY_BITS-1:0] cur_reg, cur_next;
    logic [KEY_BITS-1:0] lkey_reg, lkey_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [KEY_BITS-1:0] popped_reg, popped_next;
    hpq_pkg::status_t    status_reg, status_next;
    logic [KEY_BITS-1:0] top_reg;

    logic                rsp_valid_reg;
    logic [KEY_BITS-1:0] rsp_top_reg;
    logic                rsp_tvalid_reg;
    logic [CW-1:0]       rsp_total_reg;
    logic [KEY_BITS-1:0] rsp_popped_reg;
    logic [1:0]          rsp_status_reg;
    logic                rsp_load;

    logic [XW-1:0]       count_x, cap_x, depth_x, lim_x, last_x, lo_x, hi_x;
    logic [AW-1:0]       up_pos;
    logic                cmd_fire;
    logic                l_better, r_better;
    logic [KEY_BITS-1:0] best_key;

    // Priority compare: a strictly outranks b
    function automatic logic outranks(input logic mode, input logic [KEY_BITS-1:0] a,
                                      input logic [KEY_BITS-1:0] b);
        return mode ? (a < b) : (a > b);
    endfunction

    // Index arithmetic
    assign count_x = XW'(count_reg);
    assign cap_x   = XW'(cfg.capacity_limit);
    assign depth_x = XW'(DEPTH);
    assign lim_x   = (cap_x > depth_x) ? depth_x : cap_x;
    assign last_x  = count_x - XW'(1);
    assign lo_x    = (XW'(pos_reg) << 1) | XW'(1);
    assign hi_x    = lo_x + XW'(1);
    assign up_pos  = (pos_reg - AW'(1)) >> 1;

    assign cmd_fire  = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == hpq_pkg::S_IDLE);

    // Sift-down child selection: left first, right only if strictly better
    assign l_better = outranks(cfg.order_mode, lkey_reg, cur_reg);
    assign best_key = l_better ? lkey_reg : cur_reg;
    assign r_better = (hi_x < end_reg) && outranks(cfg.order_mode, ram_rdata, best_key);

    // Next state and datapath control
    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        end_next    = end_reg;
        cur_next    = cur_reg;
        lkey_next   = lkey_reg;
        count_next  = count_reg;
        popped_next = popped_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_waddr   = pos_reg;
        ram_wdata   = cur_reg;
        ram_raddr   = '0;
        rsp_load    = 1'b0;

        case (state_reg)
            hpq_pkg::S_IDLE:
            begin
                if (cmd_fire)
                begin
                    popped_next = '0;
                    status_next = hpq_pkg::ST_DONE;
                    case (cmd.func)
                        hpq_pkg::FN_INSERT:
                        begin
                            if (count_x >= lim_x)
                            begin
                                status_next = hpq_pkg::ST_FULL;
                                state_next  = hpq_pkg::S_OUT;
                            end
                            else
                            begin
                                cur_next   = cmd.key;
                                pos_next   = count_x[AW-1:0];
                                count_next = count_reg + CW'(1);
                                state_next = hpq_pkg::S_UP_CHK;
                            end
                        end
                        hpq_pkg::FN_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = hpq_pkg::ST_EMPTY;
                                state_next  = hpq_pkg::S_OUT;
                            end
                            else
                            begin
                                popped_next = top_reg;
                                count_next  = count_reg - CW'(1);
                                end_next    = last_x;
                                ram_raddr   = last_x[AW-1:0];
                                // single entry: heap simply becomes empty
                                state_next  = (last_x == '0) ? hpq_pkg::S_OUT
                                                             : hpq_pkg::S_LAST;
                            end
                        end
                        hpq_pkg::FN_REPLACE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = hpq_pkg::ST_EMPTY;
                                state_next  = hpq_pkg::S_OUT;
                            end
                            else
                            begin
                                cur_next   = cmd.key;
                                pos_next   = '0;
                                end_next   = count_x;
                                state_next = hpq_pkg::S_DN_L;
                            end
                        end
                        default:
                        begin
                            state_next = hpq_pkg::S_OUT;
                        end
                    endcase
                end
            end

            // Last entry arrives from RAM and becomes the moving key
            hpq_pkg::S_LAST:
            begin
                cur_next   = ram_rdata;
                pos_next   = '0;
                state_next = hpq_pkg::S_DN_L;
            end

            // Sift-down: read left child or settle
            hpq_pkg::S_DN_L:
            begin
                if (lo_x < end_reg)
                begin
                    ram_raddr  = lo_x[AW-1:0];
                    state_next = hpq_pkg::S_DN_R;
                end
                else
                begin
                    ram_we     = 1'b1;
                    state_next = hpq_pkg::S_OUT;
                end
            end

            // Sift-down: latch left child, read right child
            hpq_pkg::S_DN_R:
            begin
                lkey_next  = ram_rdata;
                ram_raddr  = hi_x[AW-1:0];
                state_next = hpq_pkg::S_DN_CMP;
            end

            // Sift-down: move the winning child up into the hole, or settle
            hpq_pkg::S_DN_CMP:
            begin
                ram_we = 1'b1;
                if (r_better)
                begin
                    ram_wdata  = ram_rdata;
                    pos_next   = hi_x[AW-1:0];
                    state_next = hpq_pkg::S_DN_L;
                end
                else if (l_better)
                begin
                    ram_wdata  = lkey_reg;
                    pos_next   = lo_x[AW-1:0];
                    state_next = hpq_pkg::S_DN_L;
                end
                else
                begin
                    state_next = hpq_pkg::S_OUT;
                end
            end

            // Sift-up: at root settle, else read parent
            hpq_pkg::S_UP_CHK:
            begin
                if (pos_reg == '0)
                begin
                    ram_we     = 1'b1;
                    state_next = hpq_pkg::S_OUT;
                end
                else
                begin
                    ram_raddr  = up_pos;
                    state_next = hpq_pkg::S_UP_CMP;
                end
            end

            // Sift-up: pull parent down or settle
            hpq_pkg::S_UP_CMP:
            begin
                ram_we = 1'b1;
                if (outranks(cfg.order_mode, cur_reg, ram_rdata))
                begin
                    ram_wdata  = ram_rdata;
                    pos_next   = up_pos;
                    state_next = hpq_pkg::S_UP_CHK;
                end
                else
                begin
                    state_next = hpq_pkg::S_OUT;
                end
            end

            // Hand result to the output register once it is free
            hpq_pkg::S_OUT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = hpq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = hpq_pkg::S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hpq_pkg::S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        end_reg    <= end_next;
        cur_reg    <= cur_next;
        lkey_reg   <= lkey_next;
        popped_reg <= popped_next;
        status_reg <= status_next;
        // shadow copy of entry 0
        if (ram_we && ram_waddr == '0)
        begin
            top_reg <= ram_wdata;
        end
        if (rsp_load)
        begin
            rsp_top_reg    <= (count_reg != '0) ? top_reg : '0;
            rsp_tvalid_reg <= (count_reg != '0);
            rsp_total_reg  <= count_reg;
            rsp_popped_reg <= popped_reg;
            rsp_status_reg <= status_reg;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.top_key     = rsp_top_reg;
    assign rsp.top_valid   = rsp_tvalid_reg;
    assign rsp.entry_total = rsp_total_reg;
    assign rsp.popped_key  = rsp_popped_reg;
    assign rsp.status      = rsp_status_reg;

endmodule

// File: hw/rtl/hpq_checker.sv
// ============================================================================
// hpq_checker
// Port-level checks on the response word of the heap priority queue.
// ============================================================================
module hpq_checker #(
    parameter int KEY_BITS = hpq_pkg::KEY_BITS_DEF
) (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      rsp_valid,
    input logic                      rsp_ready,
    input logic [KEY_BITS-1:0]       top_key,
    input logic                      top_valid,
    input logic [hpq_pkg::CNT_W-1:0] entry_total,
    input logic [KEY_BITS-1:0]       popped_key,
    input logic [1:0]                status
);

    // top_valid tracks a nonzero entry count
    a_top_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (top_valid == (entry_total != '0)))
        else $error("top_valid disagrees with entry_total");

    // empty heap shows a zero top key
    a_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !top_valid) |-> (top_key == '0))
        else $error("nonzero top_key on empty heap");

    // empty status only with an empty heap and nothing popped
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == hpq_pkg::ST_EMPTY) |->
            (entry_total == '0 && popped_key == '0))
        else $error("empty status with entries or popped key");

    // a popped key only comes with a successful operation
    a_popped: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && popped_key != '0) |-> (status == hpq_pkg::ST_DONE))
        else $error("popped key with failing status");

    // stalled response word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(top_key) && $stable(entry_total) && $stable(status)))
        else $error("response word changed while stalled");

endmodule

bind binary_heap_priority_queue hpq_checker #(
    .KEY_BITS (KEY_BITS)
) u_hpq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .top_key     (rsp.top_key),
    .top_valid   (rsp.top_valid),
    .entry_total (rsp.entry_total),
    .popped_key  (rsp.popped_key),
    .status      (rsp.status)
);

// File: dv/hpq_result_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// hpq_result_checker
// Watches the command, response and configuration ports of the heap queue.
// It keeps its own copy of the heap and settings, works out the expected
// response word for each accepted command and compares it with the response
// words in order.
// ============================================================================
module hpq_result_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    hpq_cmd_if                            cmd,
    hpq_rsp_if                            rsp,
    input  logic                          cfg_we,
    input  logic [hpq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hpq_pkg::CFG_W-1:0]     cfg_data,
    output int                            mismatches,
    output int                            words_due
);
    import hpq_pkg::*;

    localparam int KB    = KEY_BITS_DEF;
    localparam int DEPTH = DEPTH_DEF;

    // One response word as the heap should report it
    typedef struct packed {
        logic [KB-1:0]    top_key;
        logic             top_valid;
        logic [CNT_W-1:0] entry_total;
        logic [KB-1:0]    popped_key;
        logic [1:0]       status;
    } heap_view_t;

    // Shadow heap and settings
    logic [KB-1:0]    shadow_keys [DEPTH];
    int unsigned      shadow_count;
    logic             shadow_order;
    logic [CNT_W-1:0] shadow_cap;

    heap_view_t       views_due [$];
    int               errs;

    // Strictly better under the current ordering; ties never move
    function automatic logic ranks_above(logic [KB-1:0] a, logic [KB-1:0] b);
        return shadow_order ? (a < b) : (a > b);
    endfunction

    function automatic void swap_keys(int unsigned i, int unsigned j);
        logic [KB-1:0] t;
        t = shadow_keys[i];
        shadow_keys[i] = shadow_keys[j];
        shadow_keys[j] = t;
    endfunction

    // Move the top entry down; left child is tried first
    function automatic void sink_from_top(int unsigned span);
        int unsigned pos;
        int unsigned best;
        bit          moving;
        pos    = 0;
        moving = 1'b1;
        while (moving) begin
            best = pos;
            if (2 * pos + 1 < span && ranks_above(shadow_keys[2 * pos + 1], shadow_keys[best]))
                best = 2 * pos + 1;
            if (2 * pos + 2 < span && ranks_above(shadow_keys[2 * pos + 2], shadow_keys[best]))
                best = 2 * pos + 2;
            if (best == pos) begin
                moving = 1'b0;
            end
            else begin
                swap_keys(pos, best);
                pos = best;
            end
        end
    endfunction

    // Move a new entry up toward the top
    function automatic void rise_from(int unsigned start);
        int unsigned pos;
        int unsigned parent;
        bit          moving;
        pos    = start;
        moving = 1'b1;
        while (moving && pos > 0) begin
            parent = (pos - 1) / 2;
            if (ranks_above(shadow_keys[pos], shadow_keys[parent])) begin
                swap_keys(pos, parent);
                pos = parent;
            end
            else begin
                moving = 1'b0;
            end
        end
    endfunction

    // Apply one command to the shadow heap and return the expected word
    function automatic heap_view_t apply_heap_op(logic [1:0] op, logic [KB-1:0] key);
        heap_view_t    view;
        int unsigned   lim;
        int unsigned   last;
        logic [KB-1:0] popped;
        logic [1:0]    st;
        popped = '0;
        st     = ST_DONE;
        lim    = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
        case (op)
            FN_INSERT: begin
                if (shadow_count >= lim) begin
                    st = ST_FULL;
                end
                else begin
                    shadow_keys[shadow_count] = key;
                    rise_from(shadow_count);
                    shadow_count++;
                end
            end
            FN_POP: begin
                if (shadow_count == 0) begin
                    st = ST_EMPTY;
                end
                else begin
                    last              = shadow_count - 1;
                    popped            = shadow_keys[0];
                    shadow_keys[0]    = shadow_keys[last];
                    shadow_keys[last] = '0;
                    shadow_count      = last;
                    sink_from_top(last);
                end
            end
            FN_REPLACE: begin
                if (shadow_count == 0) begin
                    st = ST_EMPTY;
                end
                else begin
                    shadow_keys[0] = key;
                    sink_from_top(shadow_count);
                end
            end
            default: ;  // unused code: heap untouched
        endcase
        view.top_key     = (shadow_count != 0) ? shadow_keys[0] : '0;
        view.top_valid   = (shadow_count != 0);
        view.entry_total = shadow_count[CNT_W-1:0];
        view.popped_key  = popped;
        view.status      = st;
        return view;
    endfunction

    // Track config writes, compare responses, predict commands
    always @(posedge clk or negedge rst_n)
    begin : watch
        heap_view_t got;
        heap_view_t want;
        if (!rst_n) begin
            shadow_count = 0;
            shadow_order = 1'b0;
            shadow_cap   = CAP_RESET;
            views_due.delete();
            errs         = 0;
            mismatches  <= 0;
            words_due   <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_ORDER_MODE: shadow_order = cfg_data[0];
                    REG_CAPACITY:   shadow_cap   = cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end

            if (rsp.valid && rsp.ready) begin
                got.top_key     = rsp.top_key;
                got.top_valid   = rsp.top_valid;
                got.entry_total = rsp.entry_total;
                got.popped_key  = rsp.popped_key;
                got.status      = rsp.status;
                if (views_due.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("[%0t] response word with none outstanding: top %h/%b total %0d popped %h status %0d",
                                 $time, got.top_key, got.top_valid, got.entry_total,
                                 got.popped_key, got.status);
                end
                else begin
                    want = views_due.pop_front();
                    if (got.top_key !== want.top_key || got.top_valid !== want.top_valid
                        || got.entry_total !== want.entry_total
                        || got.popped_key !== want.popped_key || got.status !== want.status)
                    begin
                        errs++;
                        if (errs <= 10) begin
                            $display("[%0t] response mismatch", $time);
                            $display("    expected top %h/%b total %0d popped %h status %0d",
                                     want.top_key, want.top_valid, want.entry_total,
                                     want.popped_key, want.status);
                            $display("    actual   top %h/%b total %0d popped %h status %0d",
                                     got.top_key, got.top_valid, got.entry_total,
                                     got.popped_key, got.status);
                        end
                    end
                end
            end

            if (cmd.valid && cmd.ready)
                views_due.push_back(apply_heap_op(cmd.func, cmd.key));

            mismatches <= errs;
            words_due  <= views_due.size();
        end
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Testbench for the binary heap priority queue. Drives a directed set of
// corner cases and then phases of random fill/drain traffic under several
// order and capacity settings and idle patterns; the result checker beside
// the block predicts and compares every response word.
// ============================================================================
module tb_top;
    import hpq_pkg::*;

    localparam int KB        = KEY_BITS_DEF;
    localparam int HALF_NS   = 10;
    localparam int PHASES    = 8;
    localparam int PHASE_LEN = 160;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    int               mismatches;
    int               words_due;

    // Idle odds out of a hundred, per cycle
    int               send_idle_pct;
    int               recv_stall_pct;

    int               phase_cap   [PHASES] = '{64, 127, 1, 0, 7, 100, 33, 64};
    bit               phase_order [PHASES] = '{0, 1, 1, 0, 1, 0, 1, 0};

    hpq_cmd_if #(.KEY_BITS(KB)) cmd_ch ();
    hpq_rsp_if #(.KEY_BITS(KB)) rsp_ch ();

    binary_heap_priority_queue #(
        .DEPTH    (DEPTH_DEF),
        .KEY_BITS (KB)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hpq_result_checker u_result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .rsp        (rsp_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .words_due  (words_due)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #HALF_NS;
        clk = 1'b1;
        #HALF_NS;
    end

    // Response side back-pressure
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Run limit
    initial
    begin
        #(2 * HALF_NS * 1000000);
        $display("CHECK FAILED");
        $finish;
    end

    // Present one command word and hold it until taken
    task automatic send_word(input logic [1:0] op, input logic [KB-1:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.func  <= op;
        cmd_ch.key   <= key;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    // Stop sending until every outstanding response has come back
    task automatic wait_for_quiet();
        cmd_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (words_due != 0);
    endtask

    // Write both registers while the block is idle
    task automatic set_config(input bit order, input int cap);
        logic [CFG_W-1:0] noise;
        wait_for_quiet();
        noise     = CFG_W'($urandom);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ORDER_MODE;
        cfg_data  <= {noise[CFG_W-1:1], order};
        @(posedge clk);
        cfg_index <= REG_CAPACITY;
        cfg_data  <= CFG_W'(cap);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Keys: extremes, a narrow band for ties, and full-range values
    function automatic logic [KB-1:0] draw_key();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return KB'($urandom_range(15));
            default: return KB'($urandom);
        endcase
    endfunction

    // Operation mix: a fill run leans to inserts, a drain run to pops
    function automatic logic [1:0] draw_op(input bit filling);
        int r;
        r = $urandom_range(99);
        if (filling) begin
            if (r < 72) return FN_INSERT;
            if (r < 82) return FN_POP;
            if (r < 96) return FN_REPLACE;
        end
        else begin
            if (r < 15) return FN_INSERT;
            if (r < 75) return FN_POP;
            if (r < 95) return FN_REPLACE;
        end
        return 2'd3;
    endfunction

    // Stimulus and verdict
    initial
    begin : stimulus
        bit filling;
        int run_left;
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= REG_ORDER_MODE;
        cfg_data       <= '0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.func    <= FN_INSERT;
        cmd_ch.key     <= '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty heap, then reset settings (largest on top, 64 deep)
        send_word(FN_POP, '0);
        send_word(FN_REPLACE, 32'd5);
        send_word(2'd3, '1);
        send_word(FN_INSERT, '0);
        send_word(FN_INSERT, '1);
        send_word(FN_INSERT, 32'd7);
        send_word(FN_INSERT, 32'd7);
        send_word(FN_INSERT, 32'h8000_0000);
        send_word(2'd3, 32'h5A5A_A5A5);
        send_word(FN_REPLACE, '0);
        send_word(FN_REPLACE, '1);
        repeat (5) send_word(FN_POP, '0);
        send_word(FN_POP, '1);

        // Zero capacity drops every insert
        set_config(1'b1, 0);
        send_word(FN_INSERT, 32'd3);
        send_word(FN_POP, '0);

        // Small capacity, then a limit below the current count
        set_config(1'b1, 2);
        send_word(FN_INSERT, 32'd9);
        send_word(FN_INSERT, 32'd1);
        send_word(FN_INSERT, 32'd5);
        set_config(1'b1, 1);
        send_word(FN_INSERT, 32'd4);
        send_word(FN_REPLACE, 32'h55);
        send_word(FN_POP, '0);

        // Random phases
        for (int p = 0; p < PHASES; p++) begin
            set_config(phase_order[p], phase_cap[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            filling  = 1'b1;
            run_left = 80;
            for (int i = 0; i < PHASE_LEN; i++) begin
                if (run_left == 0) begin
                    filling  = !filling;
                    run_left = $urandom_range(10, 90);
                end
                run_left--;
                send_word(draw_op(filling), draw_key());
                if ($urandom_range(49) == 0)
                    wait_for_quiet();
            end
        end

        wait_for_quiet();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
